@@ src/pot_pkg.sv @@
// ----------------------------------------------------------------------------
// pot_pkg: shared definitions for the polygon orientation test
// Coordinate width, queue sizing and the job record passed from the vertex
// tracker to the determinant pipeline.
// ----------------------------------------------------------------------------
package pot_pkg;

   localparam int COORD_WIDTH = 32;           // coordinate bits used, 8 to 32
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int DET_WIDTH   = PROD_WIDTH + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // One orientation job: neighbours a and c around the lowest vertex b.
   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type cx;
      coord_type cy;
      logic      too_few;
   } job_type;

endpackage

@@ src/pot_if.sv @@
// ----------------------------------------------------------------------------
// pot_if: stream interfaces of the polygon orientation test
// Vertex channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pot_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] vertex_x;
   logic [31:0] vertex_y;
   logic        final_vertex;

   modport source (output valid, output vertex_x, output vertex_y,
                   output final_vertex, input ready);
   modport sink   (input valid, input vertex_x, input vertex_y,
                   input final_vertex, output ready);
endinterface

interface pot_rsp_if;
   logic valid;
   logic ready;
   logic is_clockwise;
   logic too_few_points;

   modport source (output valid, output is_clockwise, output too_few_points,
                   input ready);
   modport sink   (input valid, input is_clockwise, input too_few_points,
                   output ready);
endinterface

@@ src/pot_front.sv @@
// ----------------------------------------------------------------------------
// pot_front: lowest vertex tracker
// Follows the lowest vertex and its neighbours and emits one job per polygon.
// ----------------------------------------------------------------------------
module pot_front
   import pot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  logic [31:0] in_x,
   input  logic [31:0] in_y,
   input  logic    in_final,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);

   coord_type first_x_ff,  first_y_ff,  first_x_in,  first_y_in;
   coord_type prior_x_ff,  prior_y_ff;
   coord_type low_x_ff,    low_y_ff,    low_x_in,    low_y_in;
   coord_type bef_x_ff,    bef_y_ff,    bef_x_in,    bef_y_in;
   coord_type aft_x_ff,    aft_y_ff,    aft_x_in,    aft_y_in;
   logic      low_first_ff, low_first_in;
   logic      aft_pend_ff,  aft_pend_in;
   logic [1:0] seen_ff, seen_in;

   coord_type x, y;
   logic      take, lower;

   assign x        = coord_type'(in_x[COORD_WIDTH-1:0]);
   assign y        = coord_type'(in_y[COORD_WIDTH-1:0]);
   assign in_ready = job_ready;
   assign take     = in_valid && in_ready;
   assign lower    = (y < low_y_ff) || ((y == low_y_ff) && (x < low_x_ff));

   always_comb begin
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      low_x_in     = low_x_ff;
      low_y_in     = low_y_ff;
      bef_x_in     = bef_x_ff;
      bef_y_in     = bef_y_ff;
      aft_x_in     = aft_x_ff;
      aft_y_in     = aft_y_ff;
      low_first_in = low_first_ff;
      aft_pend_in  = aft_pend_ff;
      if (seen_ff == 2'd0) begin
         first_x_in   = x;
         first_y_in   = y;
         low_x_in     = x;
         low_y_in     = y;
         low_first_in = 1'b1;
         aft_pend_in  = 1'b1;
      end else begin
         if (aft_pend_ff) begin
            aft_x_in    = x;
            aft_y_in    = y;
            aft_pend_in = 1'b0;
         end
         if (lower) begin
            low_x_in     = x;
            low_y_in     = y;
            bef_x_in     = prior_x_ff;
            bef_y_in     = prior_y_ff;
            low_first_in = 1'b0;
            aft_pend_in  = 1'b1;
         end
      end
      if (in_final) begin
         seen_in = 2'd0;
      end else if (seen_ff == 2'd3) begin
         seen_in = seen_ff;
      end else begin
         seen_in = seen_ff + 2'd1;
      end
   end

   // The job is built from the updated state; a lowest first vertex has the
   // final vertex as its predecessor, a lowest last vertex the first as successor.
   always_comb begin
      job.ax      = low_first_in ? x : bef_x_in;
      job.ay      = low_first_in ? y : bef_y_in;
      job.bx      = low_x_in;
      job.by      = low_y_in;
      job.cx      = aft_pend_in ? first_x_in : aft_x_in;
      job.cy      = aft_pend_in ? first_y_in : aft_y_in;
      job.too_few = (seen_ff < 2'd2);
   end
   assign job_valid = in_valid && in_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 2'd0;
         low_first_ff <= 1'b0;
         aft_pend_ff  <= 1'b0;
      end else if (take) begin
         seen_ff      <= seen_in;
         low_first_ff <= in_final ? 1'b0 : low_first_in;
         aft_pend_ff  <= in_final ? 1'b0 : aft_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prior_x_ff <= x;
         prior_y_ff <= y;
         low_x_ff   <= low_x_in;
         low_y_ff   <= low_y_in;
         bef_x_ff   <= bef_x_in;
         bef_y_ff   <= bef_y_in;
         aft_x_ff   <= aft_x_in;
         aft_y_ff   <= aft_y_in;
      end
   end

endmodule

@@ src/pot_queue.sv @@
// ----------------------------------------------------------------------------
// pot_queue: job queue
// Small first-in first-out buffer between the tracker and the pipeline.
// ----------------------------------------------------------------------------
module pot_queue
   import pot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic                  push, pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + QUEUE_AW'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + (QUEUE_AW+1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/pot_back.sv @@
// ----------------------------------------------------------------------------
// pot_back: determinant pipeline
// Differences, two products, then the sign of their difference.
// ----------------------------------------------------------------------------
module pot_back
   import pot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   output logic    out_valid,
   input  logic    out_ready,
   output logic    out_clockwise,
   output logic    out_too_few
);

   typedef logic signed [DIFF_WIDTH-1:0] diff_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [DET_WIDTH-1:0]  det_type;

   logic     advance;
   logic     v1_ff, v2_ff, out_valid_ff;
   diff_type dxb_ff, dyb_ff, dxc_ff, dyc_ff;
   logic     few1_ff, few2_ff, few_out_ff;
   prod_type p1_ff, p2_ff;
   logic     cw_ff;
   det_type  det;

   // The whole pipeline moves together whenever the output slot can take data.
   assign advance   = !out_valid_ff || out_ready;
   assign job_ready = advance;

   assign det = det_type'(p1_ff) - det_type'(p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= job_valid;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dxb_ff     <= diff_type'(job.bx) - diff_type'(job.ax);
         dyb_ff     <= diff_type'(job.by) - diff_type'(job.ay);
         dxc_ff     <= diff_type'(job.cx) - diff_type'(job.ax);
         dyc_ff     <= diff_type'(job.cy) - diff_type'(job.ay);
         few1_ff    <= job.too_few;
         p1_ff      <= prod_type'(dxb_ff) * prod_type'(dyc_ff);
         p2_ff      <= prod_type'(dyb_ff) * prod_type'(dxc_ff);
         few2_ff    <= few1_ff;
         cw_ff      <= !few2_ff && det[DET_WIDTH-1];
         few_out_ff <= few2_ff;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_clockwise = cw_ff;
   assign out_too_few   = few_out_ff;

endmodule

@@ src/polygon_orientation_test.sv @@
// ----------------------------------------------------------------------------
// polygon_orientation_test: winding direction of a simple polygon
// Finds the lowest vertex of a vertex stream and decides orientation exactly.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer on the request channel, the last vertex of
// a polygon marked by final_vertex, and the block takes one vertex every clock
// cycle, unless the job queue is full, with no gaps between polygons. Only the
// low COORD_WIDTH bits of each coordinate are used, read as two's complement.
// For every polygon exactly one result transfer leaves on the response channel:
// is_clockwise is set when the cross product of (b - a) and (c - a) is
// negative, where b is the lowest vertex (least y, then least x, the earliest
// one on ties) and a and c are its predecessor and successor around the closed
// outline. Polygons of fewer than three vertices give too_few_points set and
// is_clockwise clear. The sign is exact: the products are formed at full
// width. A result is registered through the job queue slot, the differences,
// the two products and the sign of their difference, the last straight into
// the output.
// A two-entry job queue sits between the vertex tracker and the pipeline, so
// a stalled response channel holds vertices back only once two polygons are
// finished and waiting.
// ----------------------------------------------------------------------------
module polygon_orientation_test
   import pot_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   pot_req_if.sink   req_ch,
   pot_rsp_if.source rsp_ch
);

   logic    fr_valid, fr_ready;
   job_type fr_job;
   logic    bk_valid, bk_ready;
   job_type bk_job;

   // Front part: follows the lowest vertex and its neighbours.
   pot_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_x      (req_ch.vertex_x),
      .in_y      (req_ch.vertex_y),
      .in_final  (req_ch.final_vertex),
      .job_valid (fr_valid),
      .job_ready (fr_ready),
      .job       (fr_job)
   );

   // Queue of finished polygons awaiting their determinant.
   pot_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_job   (fr_job),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_job    (bk_job)
   );

   // Back part: exact sign of the cross product.
   pot_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (bk_valid),
      .job_ready     (bk_ready),
      .job           (bk_job),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .out_clockwise (rsp_ch.is_clockwise),
      .out_too_few   (rsp_ch.too_few_points)
   );

endmodule
